@@ src/bvc_pkg.sv @@
// ---------------------------------------------------------------------------
// bvc_pkg: shared types and constants of the balance/velocity controller
// Field widths, fixed-point constants, configuration record and the control
// word format of the microcoded sequencer.
// ---------------------------------------------------------------------------
package bvc_pkg;

  // Loop constants
  localparam int SAMPLE_PERIOD  = 5;
  localparam int INTEGRAL_LIMIT = 3000;
  localparam int DRIVE_LIMIT    = 250;

  // Field widths
  localparam int ANGLE_W  = 17;
  localparam int RATE_W   = 17;
  localparam int COUNT_W  = 9;
  localparam int DRIVE_W  = 9;
  localparam int GAIN_W   = 22;
  localparam int SPTGT_W  = 14;
  localparam int TIP_W    = 16;
  localparam int DZ_W     = 8;
  localparam int TICK_W   = 3;

  // Datapath widths
  localparam int ACC_W       = COUNT_W + $clog2(SAMPLE_PERIOD);
  localparam int ERR_W       = 15;
  localparam int FILT_W      = 23;
  localparam int FSUM_W      = 26;
  localparam int FMAG_W      = 24;
  localparam int INT_W       = 13;
  localparam int ISUM_W      = 16;
  localparam int OP_W        = 25;
  localparam int PROD_W      = 2 * OP_W;
  localparam int SUM_W       = 48;
  localparam int GAIN_SHIFT  = 24;
  localparam int TERM_W      = SUM_W - GAIN_SHIFT;
  localparam int RECIP_SHIFT = 26;
  localparam int FDIV_W      = FILT_W - 8;

  // ceil(2^26 / 5): exact floor(x / 5) for every x below 2^26
  localparam logic signed [OP_W-1:0] RECIP5 = 25'sd13421773;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_BAL_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAL_RATE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_PROP_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_INT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIP_LIMIT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd7;

  // Payload types
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [RATE_W-1:0]  rate_t;
  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         balance_prop_gain;
    logic [GAIN_W-1:0]         balance_rate_gain;
    logic [GAIN_W-1:0]         speed_prop_gain;
    logic [GAIN_W-1:0]         speed_int_gain;
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [SPTGT_W-1:0] speed_target;
    logic [TIP_W-1:0]          tip_limit;
    logic [DZ_W-1:0]           dead_zone;
  } cfg_t;

  // Micro-op codes
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_NONE     = 3'd0;
  localparam mul_sel_t MUL_KP_ANG   = 3'd1;
  localparam mul_sel_t MUL_KD_RATE  = 3'd2;
  localparam mul_sel_t MUL_RECIP5   = 3'd3;
  localparam mul_sel_t MUL_KPV_FILT = 3'd4;
  localparam mul_sel_t MUL_KIV_INT  = 3'd5;

  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD = 2'd0;
  localparam acc_op_t ACC_LOAD = 2'd1;
  localparam acc_op_t ACC_ADD  = 2'd2;

  typedef logic [2:0] wb_t;
  localparam wb_t WB_NONE = 3'd0;
  localparam wb_t WB_FSUM = 3'd1;
  localparam wb_t WB_BAL  = 3'd2;
  localparam wb_t WB_FILT = 3'd3;
  localparam wb_t WB_INT  = 3'd4;
  localparam wb_t WB_VEL  = 3'd5;
  localparam wb_t WB_OUT  = 3'd6;

  localparam int PC_W = 4;

  typedef struct packed {
    mul_sel_t        mul;
    acc_op_t         acc;
    wb_t             wb;
    logic            jmp_tipped;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  localparam uword_t UWORD_NOP = '{
    mul: MUL_NONE, acc: ACC_HOLD, wb: WB_NONE,
    jmp_tipped: 1'b0, target: '0, last: 1'b0
  };

  typedef struct packed {
    logic tipped;
    logic out_full;
  } status_t;

endpackage

@@ src/bvc_if.sv @@
// ---------------------------------------------------------------------------
// bvc_if: valid/ready channels of the balance/velocity controller
// One interface for the sensor tick channel and one for the drive channel.
// ---------------------------------------------------------------------------
interface bvc_in_if import bvc_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t roll_angle;
  rate_t  pitch_rate;
  count_t left_count_delta;
  count_t right_count_delta;

  modport source (
    output valid, roll_angle, pitch_rate, left_count_delta, right_count_delta,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_rate, left_count_delta, right_count_delta,
    output ready
  );
endinterface

interface bvc_out_if import bvc_pkg::*; ();
  logic   valid;
  logic   ready;
  drive_t left_drive;
  drive_t right_drive;
  logic   tipped;

  modport source (
    output valid, left_drive, right_drive, tipped,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, tipped,
    output ready
  );
endinterface

@@ src/bvc_cfg.sv @@
// ---------------------------------------------------------------------------
// bvc_cfg: configuration register file
// Eight write-only registers loaded from a plain indexed write port.
// ---------------------------------------------------------------------------
module bvc_cfg import bvc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.balance_prop_gain <= 22'd786432;
      cfg.balance_rate_gain <= 22'd655360;
      cfg.speed_prop_gain   <= 22'd52429;
      cfg.speed_int_gain    <= 22'd262;
      cfg.target_angle      <= '0;
      cfg.speed_target      <= '0;
      cfg.tip_limit         <= 16'd7680;
      cfg.dead_zone         <= 8'd20;
    end else if (wr_en) begin
      case (index)
        REG_BAL_PROP_GAIN: cfg.balance_prop_gain <= data[GAIN_W-1:0];
        REG_BAL_RATE_GAIN: cfg.balance_rate_gain <= data[GAIN_W-1:0];
        REG_SPD_PROP_GAIN: cfg.speed_prop_gain   <= data[GAIN_W-1:0];
        REG_SPD_INT_GAIN:  cfg.speed_int_gain    <= data[GAIN_W-1:0];
        REG_TARGET_ANGLE:  cfg.target_angle      <= data[ANGLE_W-1:0];
        REG_SPEED_TARGET:  cfg.speed_target      <= data[SPTGT_W-1:0];
        REG_TIP_LIMIT:     cfg.tip_limit         <= data[TIP_W-1:0];
        REG_DEAD_ZONE:     cfg.dead_zone         <= data[DZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/bvc_seq.sv @@
// ---------------------------------------------------------------------------
// bvc_seq: microcode sequencer
// Holds the control program, the step counter and the busy flag, and issues
// one control word per cycle to the datapath (a no-op while idle or held).
// ---------------------------------------------------------------------------
module bvc_seq import bvc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output uword_t  uop
);

  localparam logic [PC_W-1:0] STEP_BAL_P   = 4'd0;
  localparam logic [PC_W-1:0] STEP_BAL_D   = 4'd1;
  localparam logic [PC_W-1:0] STEP_BAL_SUM = 4'd2;
  localparam logic [PC_W-1:0] STEP_DIV5    = 4'd3;
  localparam logic [PC_W-1:0] STEP_FILT    = 4'd4;
  localparam logic [PC_W-1:0] STEP_INTEG   = 4'd5;
  localparam logic [PC_W-1:0] STEP_VEL_P   = 4'd6;
  localparam logic [PC_W-1:0] STEP_VEL_SUM = 4'd7;
  localparam logic [PC_W-1:0] STEP_VEL     = 4'd8;
  localparam logic [PC_W-1:0] STEP_OUT     = 4'd9;

  logic            busy;
  logic [PC_W-1:0] pc;
  uword_t          word;
  logic            hold;

  // Control store. A result can only be written in the last step, which
  // waits while the output register is still occupied.
  function automatic uword_t rom(input logic [PC_W-1:0] step);
    uword_t uw;
    uw = UWORD_NOP;
    case (step)
      STEP_BAL_P: begin
        uw.mul        = MUL_KP_ANG;
        uw.jmp_tipped = 1'b1;
        uw.target     = STEP_OUT;
      end
      STEP_BAL_D: begin
        uw.mul = MUL_KD_RATE;
        uw.acc = ACC_LOAD;
      end
      STEP_BAL_SUM: begin
        uw.acc = ACC_ADD;
        uw.wb  = WB_FSUM;
      end
      STEP_DIV5: begin
        uw.mul = MUL_RECIP5;
        uw.wb  = WB_BAL;
      end
      STEP_FILT: begin
        uw.wb = WB_FILT;
      end
      STEP_INTEG: begin
        uw.mul = MUL_KPV_FILT;
        uw.wb  = WB_INT;
      end
      STEP_VEL_P: begin
        uw.mul = MUL_KIV_INT;
        uw.acc = ACC_LOAD;
      end
      STEP_VEL_SUM: begin
        uw.acc = ACC_ADD;
      end
      STEP_VEL: begin
        uw.wb = WB_VEL;
      end
      STEP_OUT: begin
        uw.wb   = WB_OUT;
        uw.last = 1'b1;
      end
      default: begin
        uw = UWORD_NOP;
      end
    endcase
    return uw;
  endfunction

  assign word     = rom(pc);
  assign hold     = word.last && status.out_full;
  assign uop      = (busy && !hold) ? word : UWORD_NOP;
  assign in_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      pc <= '0;
      if (in_valid) begin
        busy <= 1'b1;
      end
    end else if (!hold) begin
      if (word.last) begin
        busy <= 1'b0;
      end else if (word.jmp_tipped && status.tipped) begin
        pc <= word.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

@@ src/bvc_dp.sv @@
// ---------------------------------------------------------------------------
// bvc_dp: controller datapath
// Encoder accumulation and tip test at the transfer, then one shared signed
// multiplier, a wide accumulator and the loop state, all steered by micro-ops.
// ---------------------------------------------------------------------------
module bvc_dp import bvc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  angle_t roll_angle,
  input  rate_t  pitch_rate,
  input  count_t left_count_delta,
  input  count_t right_count_delta,
  input  cfg_t   cfg,
  input  uword_t uop,
  input  logic   out_ready,
  output status_t status,
  output logic   out_valid,
  output drive_t left_drive,
  output drive_t right_drive,
  output logic   tipped
);

  localparam logic signed [ISUM_W-1:0]  ISUM_MAX = ISUM_W'(INTEGRAL_LIMIT);
  localparam logic signed [TERM_W:0]    DIFF_MAX = (TERM_W+1)'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] DRV_MAX  = DRIVE_W'(DRIVE_LIMIT);

  // Loop state
  logic signed [ACC_W-1:0]  left_accum;
  logic signed [ACC_W-1:0]  right_accum;
  logic [TICK_W-1:0]        tick_count;
  logic signed [ACC_W-1:0]  left_speed;
  logic signed [ACC_W-1:0]  right_speed;
  logic signed [FILT_W-1:0] speed_filter;
  logic signed [INT_W-1:0]  speed_integral;

  // Item registers and working registers
  angle_t                   roll_r;
  rate_t                    rate_r;
  logic                     tip_r;
  logic [FMAG_W-1:0]        fmag;
  logic                     fneg;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic signed [TERM_W-1:0] bal;
  logic signed [TERM_W-1:0] vel;

  // Combinational
  logic signed [ACC_W-1:0]   left_sum;
  logic signed [ACC_W-1:0]   right_sum;
  logic [TICK_W-1:0]         tick_next;
  logic                      latch;
  logic [ANGLE_W:0]          roll_mag;
  logic                      tip_now;
  logic signed [ANGLE_W:0]   ang_err;
  logic signed [ERR_W-1:0]   speed_err;
  logic signed [FSUM_W-1:0]  fsum;
  logic signed [FSUM_W-1:0]  fsum_abs;
  logic signed [OP_W-1:0]    mul_a;
  logic signed [OP_W-1:0]    mul_b;
  logic [FILT_W-2:0]         quot;
  logic signed [FILT_W-1:0]  filt_biased;
  logic signed [FDIV_W-1:0]  fdiv;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [TERM_W:0]    diff;
  logic signed [DRIVE_W-1:0] sat;
  logic [DRIVE_W-1:0]        mag;
  logic signed [DRIVE_W-1:0] drv;

  // Division by 2^24 rounded toward zero
  function automatic logic signed [TERM_W-1:0] gain_trunc(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] biased;
    biased = v[SUM_W-1] ? v + SUM_W'((64'd1 << GAIN_SHIFT) - 64'd1) : v;
    return biased[SUM_W-1:GAIN_SHIFT];
  endfunction

  // Speed accumulation and tip test on the incoming item
  assign left_sum  = left_accum + ACC_W'(left_count_delta);
  assign right_sum = right_accum + ACC_W'(right_count_delta);
  assign tick_next = tick_count + 1'b1;
  assign latch     = (tick_next >= TICK_W'(SAMPLE_PERIOD)) || (tick_next == '0);
  assign roll_mag  = roll_angle[ANGLE_W-1] ? -(ANGLE_W+1)'(roll_angle)
                                           : (ANGLE_W+1)'(roll_angle);
  assign tip_now   = roll_mag > (ANGLE_W+1)'(cfg.tip_limit);

  // Operand sources
  assign ang_err   = (ANGLE_W+1)'(roll_r) - (ANGLE_W+1)'(cfg.target_angle);
  assign speed_err = ERR_W'(left_speed) + ERR_W'(right_speed)
                   - ERR_W'(cfg.speed_target);
  assign fsum      = (FSUM_W'(speed_filter) <<< 2) + (FSUM_W'(speed_err) <<< 8);
  assign fsum_abs  = fsum[FSUM_W-1] ? -fsum : fsum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uop.mul)
      MUL_KP_ANG: begin
        mul_a = {{(OP_W-GAIN_W){1'b0}}, cfg.balance_prop_gain};
        mul_b = OP_W'(ang_err);
      end
      MUL_KD_RATE: begin
        mul_a = {{(OP_W-GAIN_W){1'b0}}, cfg.balance_rate_gain};
        mul_b = OP_W'(rate_r);
      end
      MUL_RECIP5: begin
        mul_a = RECIP5;
        mul_b = {{(OP_W-FMAG_W){1'b0}}, fmag};
      end
      MUL_KPV_FILT: begin
        mul_a = {{(OP_W-GAIN_W){1'b0}}, cfg.speed_prop_gain};
        mul_b = OP_W'(speed_filter);
      end
      MUL_KIV_INT: begin
        mul_a = {{(OP_W-GAIN_W){1'b0}}, cfg.speed_int_gain};
        mul_b = OP_W'($signed({speed_integral, 8'h00}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Filter quotient: |x| * ceil(2^26/5) >> 26, sign applied afterwards
  assign quot        = prod[RECIP_SHIFT+FILT_W-2:RECIP_SHIFT];
  assign filt_biased = speed_filter[FILT_W-1] ? speed_filter + FILT_W'(255)
                                              : speed_filter;
  assign fdiv        = filt_biased[FILT_W-1:8];
  assign isum        = ISUM_W'(speed_integral) + ISUM_W'(fdiv);

  // Drive shaping: saturate, then dead zone; the right side mirrors the left
  assign diff = (TERM_W+1)'(bal) - (TERM_W+1)'(vel);
  always_comb begin
    if (diff > DIFF_MAX) begin
      sat = DRV_MAX;
    end else if (diff < -DIFF_MAX) begin
      sat = -DRV_MAX;
    end else begin
      sat = diff[DRIVE_W-1:0];
    end
    mag = sat[DRIVE_W-1] ? DRIVE_W'(-sat) : DRIVE_W'(sat);
    drv = (mag < DRIVE_W'(cfg.dead_zone)) ? '0 : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_accum     <= '0;
      right_accum    <= '0;
      tick_count     <= '0;
      left_speed     <= '0;
      right_speed    <= '0;
      speed_filter   <= '0;
      speed_integral <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        if (latch) begin
          left_speed  <= left_sum;
          right_speed <= right_sum;
          left_accum  <= '0;
          right_accum <= '0;
          tick_count  <= '0;
        end else begin
          left_accum  <= left_sum;
          right_accum <= right_sum;
          tick_count  <= tick_next;
        end
      end
      if (uop.wb == WB_FILT) begin
        speed_filter <= fneg ? -FILT_W'({1'b0, quot}) : FILT_W'({1'b0, quot});
      end
      if (uop.wb == WB_INT) begin
        if (isum > ISUM_MAX) begin
          speed_integral <= INT_W'(ISUM_MAX);
        end else if (isum < -ISUM_MAX) begin
          speed_integral <= INT_W'(-ISUM_MAX);
        end else begin
          speed_integral <= isum[INT_W-1:0];
        end
      end
      if (uop.wb == WB_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      roll_r <= roll_angle;
      rate_r <= pitch_rate;
      tip_r  <= tip_now;
    end
    if (uop.mul != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (uop.acc)
      ACC_LOAD: acc <= prod[SUM_W-1:0];
      ACC_ADD:  acc <= acc + prod[SUM_W-1:0];
      default: begin
      end
    endcase
    case (uop.wb)
      WB_FSUM: begin
        fmag <= fsum_abs[FMAG_W-1:0];
        fneg <= fsum[FSUM_W-1];
      end
      WB_BAL: bal <= gain_trunc(acc);
      WB_VEL: vel <= gain_trunc(acc);
      WB_OUT: begin
        left_drive  <= tip_r ? '0 : drv;
        right_drive <= tip_r ? '0 : -drv;
        tipped      <= tip_r;
      end
      default: begin
      end
    endcase
  end

  assign status.tipped   = tip_r;
  assign status.out_full = out_valid && !out_ready;

endmodule

@@ src/balance_velocity_cascade_control.sv @@
// ---------------------------------------------------------------------------
// balance_velocity_cascade_control: two-wheel balance PD plus velocity PI
// Top level: configuration registers, microcode sequencer and datapath.
// ---------------------------------------------------------------------------
// Usage:
//   The sensor channel carries one control tick per transfer: roll angle and
//   pitch rate (Q8 degrees) and the encoder edge counts of that tick. The
//   drive channel returns exactly one result per tick: left and right motor
//   commands and the tipped flag.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data, one per
//   cycle. The user must write them only while no tick is in flight; the
//   block itself does not enforce this. A tick that is not tipped runs ten
//   microcode steps on one shared 25x25 multiplier before its result is
//   written; a tipped tick jumps straight to the output step. Ticks are
//   taken one at a time, as often as the length of the microcode program
//   allows; the next tick is taken in the cycle after the last step.
//   The result sits in an output register; a new tick is accepted while it
//   waits, and the sequencer holds at its output step until that register
//   is free. Synchronous reset clears the loop state, restores the register
//   defaults and empties the output register.
// ---------------------------------------------------------------------------
module balance_velocity_cascade_control import bvc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bvc_in_if.sink                sensor,
  bvc_out_if.source             drive
);

  cfg_t    cfg;
  uword_t  uop;
  status_t status;
  logic    in_ready;
  logic    accept;
  logic    out_valid;
  drive_t  left_drive;
  drive_t  right_drive;
  logic    tipped;

  assign accept       = sensor.valid && in_ready;
  assign sensor.ready = in_ready;

  bvc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  bvc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sensor.valid),
    .in_ready (in_ready),
    .status   (status),
    .uop      (uop)
  );

  bvc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .roll_angle        (sensor.roll_angle),
    .pitch_rate        (sensor.pitch_rate),
    .left_count_delta  (sensor.left_count_delta),
    .right_count_delta (sensor.right_count_delta),
    .cfg               (cfg),
    .uop               (uop),
    .out_ready         (drive.ready),
    .status            (status),
    .out_valid         (out_valid),
    .left_drive        (left_drive),
    .right_drive       (right_drive),
    .tipped            (tipped)
  );

  assign drive.valid       = out_valid;
  assign drive.left_drive  = left_drive;
  assign drive.right_drive = right_drive;
  assign drive.tipped      = tipped;

endmodule

@@ src/bvc_checker.sv @@
// ---------------------------------------------------------------------------
// bvc_checker: port-level checks of the balance/velocity controller
// Watches the channel ports of the top level over time; bound to it below.
// ---------------------------------------------------------------------------
module bvc_checker import bvc_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input drive_t left_drive,
  input drive_t right_drive,
  input logic   tipped
);

  localparam drive_t DRV_MAX = DRIVE_W'(DRIVE_LIMIT);

  // A tipped result never drives the motors.
  a_tip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && tipped |-> left_drive == '0 && right_drive == '0)
    else $error("tipped result with nonzero drive");

  // The two sides are mirror images and stay within the drive limit.
  a_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_drive == -left_drive) && (left_drive <= DRV_MAX)
                  && (left_drive >= -DRV_MAX))
    else $error("drive outputs not mirrored or out of range");

  // The block works on one tick at a time: after a transfer it is busy.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sensor channel ready right after a transfer");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_drive)
                                && $stable(right_drive) && $stable(tipped))
    else $error("stalled result changed or dropped");

endmodule

bind balance_velocity_cascade_control bvc_checker u_bvc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sensor.valid),
  .in_ready    (sensor.ready),
  .out_valid   (drive.valid),
  .out_ready   (drive.ready),
  .left_drive  (drive.left_drive),
  .right_drive (drive.right_drive),
  .tipped      (drive.tipped)
);
